// ===== sv/rpn_pkg.sv =====
// Shared types and codes for the stack-machine evaluator.
// No dependencies; compile first.
`default_nettype none

package rpn_pkg;

   // Instruction codes carried in the op field of a request beat.
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_NEGATE = 3'd5
   } rpn_op_type;

   localparam int OP_WIDTH = 3;

   // Completion status returned with every result beat.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_DIVZ  = 2'd2,
      ST_OVER  = 2'd3
   } rpn_status_type;

   // Command from the sequencer to the multiply/divide unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } rpn_unit_cmd_type;

endpackage

`default_nettype wire

// ===== sv/rpn_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on rpn_pkg.
`default_nettype none

interface rpn_req_if import rpn_pkg::*; #(
   parameter int WORD_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic [OP_WIDTH-1:0]          op;
   logic signed [WORD_WIDTH-1:0] operand;
   logic                         last;

   modport source (output valid, output op, output operand, output last, input ready);
   modport sink   (input valid, input op, input operand, input last, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; #(
   parameter int WORD_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] value;
   rpn_status_type               status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_muldiv.sv =====
// Iterative multiply/divide unit, one bit per cycle (shift-add and restoring division).
// Depends on rpn_pkg.
`default_nettype none

module rpn_muldiv import rpn_pkg::*; #(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rpn_unit_cmd_type      cmd,
   input  wire logic [WORD_WIDTH-1:0] a,
   input  wire logic [WORD_WIDTH-1:0] b,
   output logic                       done,
   output logic [WORD_WIDTH-1:0]      result
);

   localparam int CW = $clog2(WORD_WIDTH);

   typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIX} unit_state_type;

   unit_state_type        state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  is_div_ff, is_div_in;
   logic                  neg_ff, neg_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [WORD_WIDTH-1:0] x_ff, x_in;
   logic [WORD_WIDTH-1:0] y_ff, y_in;
   logic [WORD_WIDTH:0]   shifted;
   logic [WORD_WIDTH:0]   diff;
   logic [WORD_WIDTH-1:0] a_mag;
   logic [WORD_WIDTH-1:0] b_mag;

   assign a_mag   = a[WORD_WIDTH-1] ? (~a + 1'b1) : a;
   assign b_mag   = b[WORD_WIDTH-1] ? (~b + 1'b1) : b;
   assign shifted = {acc_ff, x_ff[WORD_WIDTH-1]};
   assign diff    = shifted - {1'b0, y_ff};

   assign done   = (state_ff == U_FIX);
   assign result = is_div_ff ? (neg_ff ? (~x_ff + 1'b1) : x_ff) : acc_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               is_div_in = cmd.is_div;
               neg_in    = a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
               acc_in    = '0;
               x_in      = cmd.is_div ? a_mag : a;
               y_in      = cmd.is_div ? b_mag : b;
               count_in  = CW'(WORD_WIDTH - 1);
               state_in  = U_RUN;
            end
         end
         U_RUN: begin
            if (is_div_ff) begin
               // Restoring step: the quotient bits shift in where the dividend shifts out.
               if (shifted >= {1'b0, y_ff}) begin
                  acc_in = diff[WORD_WIDTH-1:0];
                  x_in   = {x_ff[WORD_WIDTH-2:0], 1'b1};
               end else begin
                  acc_in = shifted[WORD_WIDTH-1:0];
                  x_in   = {x_ff[WORD_WIDTH-2:0], 1'b0};
               end
            end else begin
               if (y_ff[0]) begin
                  acc_in = acc_ff + x_ff;
               end
               x_in = {x_ff[WORD_WIDTH-2:0], 1'b0};
               y_in = {1'b0, y_ff[WORD_WIDTH-1:1]};
            end
            if (count_ff == '0) begin
               state_in = U_FIX;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         U_FIX: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff  <= count_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

endmodule

`default_nettype wire

// ===== sv/rpn_stack_calculator_top.sv =====
// Top level of the reverse Polish stack-machine evaluator: sequencer, stack memory
// and result register. Depends on rpn_pkg, rpn_if and rpn_muldiv.
`default_nettype none

// Channel  Direction  Payload                              Beat taken when
// req      in         op[2:0], operand[WORD_WIDTH], last   req.valid && req.ready
// rsp      out        value[WORD_WIDTH], status[1:0]       rsp.valid && rsp.ready
//
// Push, skipped and unused instructions go from S_IDLE to S_FINISH; negate adds S_FETCH_R,
// add and subtract S_FETCH_R and S_FETCH_L; multiply and divide also wait in S_UNIT for
// the one-bit-per-cycle multiply/divide unit. A last beat that pops the top adds S_POP to read it.
// Reset empties the stack and clears the fault; the stack memory itself is not cleared,
// since only entries below the stack pointer are ever read.
// A new request is taken while a result still waits in the output register; the block
// only stalls at the end of a last beat if that register is still full.

module rpn_stack_calculator_top import rpn_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int WORD_WIDTH  = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   rpn_req_if.sink   req,
   rpn_rsp_if.source rsp
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);

   // The sequencer works on one instruction at a time. Operands are read from the
   // stack memory one per cycle and the result is written back before the next
   // instruction is taken, so a read never overlaps a pending write to the same entry.
   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH_R,
      S_FETCH_L,
      S_UNIT,
      S_FINISH,
      S_POP
   } seq_state_type;

   seq_state_type         state_ff, state_in;
   logic [SPW-1:0]        sp_ff, sp_in;
   rpn_status_type        fault_ff, fault_in;
   logic [OP_WIDTH-1:0]   op_ff, op_in;
   logic                  last_ff, last_in;
   logic [WORD_WIDTH-1:0] r_ff, r_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   rpn_status_type        rsp_status_ff, rsp_status_in;

   // Stack memory: one write port, one read port, registered read data.
   logic [WORD_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [WORD_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [WORD_WIDTH-1:0] rd_data_ff;

   logic [SPW-1:0]        sp_m1;
   logic [SPW-1:0]        sp_m2;
   logic                  accept;
   logic                  out_free;

   rpn_unit_cmd_type      unit_cmd;
   logic                  unit_done;
   logic [WORD_WIDTH-1:0] unit_result;

   assign sp_m1    = sp_ff - 1'b1;
   assign sp_m2    = sp_ff - SPW'(2);
   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.value  = rsp_value_ff;
   assign rsp.status = rsp_status_ff;

   rpn_muldiv #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .a      (rd_data_ff),
      .b      (r_ff),
      .done   (unit_done),
      .result (unit_result)
   );

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      fault_in      = fault_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      r_in          = r_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = sp_m1[AW-1:0];
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = sp_m1[AW-1:0];
      unit_cmd      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req.op;
               last_in  = req.last;
               state_in = S_FINISH;
               // Once a program has faulted, its remaining instructions are skipped.
               if (fault_ff == ST_OK) begin
                  unique case (req.op)
                     OP_PUSH: begin
                        if (sp_ff == SPW'(STACK_DEPTH)) begin
                           fault_in = ST_OVER;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = sp_ff[AW-1:0];
                           mem_wdata = req.operand;
                           sp_in     = sp_ff + 1'b1;
                        end
                     end
                     OP_NEGATE: begin
                        if (sp_ff == '0) begin
                           fault_in = ST_UNDER;
                        end else begin
                           mem_re   = 1'b1;
                           state_in = S_FETCH_R;
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (sp_ff < SPW'(2)) begin
                           fault_in = ST_UNDER;
                        end else begin
                           mem_re   = 1'b1;
                           state_in = S_FETCH_R;
                        end
                     end
                     default: begin
                        // Unused codes do nothing.
                     end
                  endcase
               end
            end
         end

         S_FETCH_R: begin
            // The top of the stack has arrived; it is the right-hand operand.
            r_in = rd_data_ff;
            if (op_ff == OP_NEGATE) begin
               mem_we    = 1'b1;
               mem_waddr = sp_m1[AW-1:0];
               mem_wdata = ~rd_data_ff + 1'b1;
               state_in  = S_FINISH;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = sp_m2[AW-1:0];
               state_in  = S_FETCH_L;
            end
         end

         S_FETCH_L: begin
            // Second from top has arrived in the read register: the left-hand operand.
            mem_waddr = sp_m2[AW-1:0];
            unique case (op_ff)
               OP_ADD: begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff + r_ff;
                  sp_in     = sp_m1;
                  state_in  = S_FINISH;
               end
               OP_SUB: begin
                  mem_we    = 1'b1;
                  mem_wdata = rd_data_ff - r_ff;
                  sp_in     = sp_m1;
                  state_in  = S_FINISH;
               end
               OP_MUL: begin
                  unit_cmd.start  = 1'b1;
                  unit_cmd.is_div = 1'b0;
                  state_in        = S_UNIT;
               end
               OP_DIV: begin
                  if (r_ff == '0) begin
                     fault_in = ST_DIVZ;
                     state_in = S_FINISH;
                  end else begin
                     unit_cmd.start  = 1'b1;
                     unit_cmd.is_div = 1'b1;
                     state_in        = S_UNIT;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         S_UNIT: begin
            mem_waddr = sp_m2[AW-1:0];
            mem_wdata = unit_result;
            if (unit_done) begin
               mem_we   = 1'b1;
               sp_in    = sp_m1;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (fault_ff != ST_OK) begin
               // A faulted program reports its first fault and leaves an empty stack.
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = fault_ff;
                  sp_in         = '0;
                  fault_in      = ST_OK;
                  state_in      = S_IDLE;
               end
            end else if (sp_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = ST_UNDER;
                  state_in      = S_IDLE;
               end
            end else begin
               mem_re   = 1'b1;
               sp_in    = sp_m1;
               state_in = S_POP;
            end
         end

         S_POP: begin
            // The read register holds the popped word until the result register frees up.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data_ff;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         fault_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      last_ff       <= last_in;
      r_ff          <= r_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= stack_mem[mem_raddr];
      end
   end

   // The stack pointer never runs past the memory.
   a_sp_in_range : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   // A result that reports a fault carries a zero value.
   a_fault_zero_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("faulted result carries a non-zero value");

   // The arithmetic unit only finishes while the sequencer waits for it.
   a_unit_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      unit_done |-> state_ff == S_UNIT)
      else $error("multiply/divide unit finished outside its wait state");

   // Ending a faulted program empties the stack and clears the fault.
   a_fault_clears_stack : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && last_ff && (fault_ff != ST_OK) && out_free
      |=> (sp_ff == '0) && (fault_ff == ST_OK))
      else $error("stack not emptied after a faulted program");

endmodule

`default_nettype wire
